// ===== rtl/diag_gmm_pkg.sv =====
// Shared types, constants and helpers for the diagonal GMM log-likelihood unit.
// Holds the input and result word structs, fixed-point constants and the 2^(-2^-(i+1)) table.
// No dependencies.
`timescale 1ns / 1ps

package diag_gmm_pkg;

    localparam int MAX_DIMS_DEF        = 32;
    localparam int MAX_MIXTURES_DEF    = 8;
    localparam int VALUE_FRAC_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIXES = 2'd1;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_MEAN    = 2'd1;
    localparam logic [1:0] OP_SIGMA   = 2'd2;
    localparam logic [1:0] OP_FEATURE = 2'd3;

    localparam int LOG_W       = 40;
    localparam int WEIGHT_FRAC = 14;
    localparam int LSE_FRAC    = 30;

    localparam logic [31:0] LN2_Q32         = 32'd2977044472;
    localparam logic [31:0] LOG2E_Q30       = 32'd1549082005;
    localparam logic [31:0] Q30_ONE         = 32'h4000_0000;
    localparam logic signed [35:0] LN_SQRT_TWO_PI_Q16 = 36'sd60224;
    localparam logic [31:0] I32_MAX         = 32'h7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN  = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         mixture_index;
        logic [4:0]         dim_index;
        logic signed [15:0] value;
        logic               frame_last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] log_likelihood;
        logic               status;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -36'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] xv;
        logic [63:0] r;
        logic [63:0] bitv;
        xv   = x;
        r    = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (bitv > xv) begin
                bitv = bitv >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bitv != 0) begin
                if (xv >= r + bitv) begin
                    xv = xv - (r + bitv);
                    r  = (r >> 1) + bitv;
                end
                else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [16*30-1:0] pow2_tab_f();
        logic [16*30-1:0] tab;
        logic [63:0]      t;
        tab = '0;
        t   = isqrt64(64'h1 << 59);
        tab[29:0] = t[29:0];
        for (int i = 1; i < 16; i++) begin
            t = isqrt64(t << 30);
            tab[i*30 +: 30] = t[29:0];
        end
        return tab;
    endfunction

    localparam logic [16*30-1:0] POW2_FRAC_TAB = pow2_tab_f();

endpackage

// ===== rtl/diag_gmm_log_likelihood_unit.sv =====
// Diagonal GMM log-likelihood unit: one 32x32 multiplier shared under a sequencer.
// Depends on diag_gmm_pkg. A mean load writes its memory; a weight load takes a log;
// a sigma load squares, divides and takes a log (a zero or negative sigma only writes
// zeros, sets the flag); a feature element updates every active mixture; a frame-closing
// element adds log-sum-exp, strobe after. A new word is taken only while idle.
// Async active-low reset clears control, config (32 dims, 8 mixtures), accumulators, flag.
`timescale 1ns / 1ps

module diag_gmm_log_likelihood_unit
    import diag_gmm_pkg::*;
#(
    parameter int MAX_DIMS        = MAX_DIMS_DEF,
    parameter int MAX_MIXTURES    = MAX_MIXTURES_DEF,
    parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH     = MAX_MIXTURES * MAX_DIMS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int K_W       = $clog2(MAX_MIXTURES + 1);
    localparam int KI_W      = (MAX_MIXTURES > 1) ? $clog2(MAX_MIXTURES) : 1;
    localparam int DIV_W     = 2 * VALUE_FRAC_BITS + 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DIST_SH   = 2 * VALUE_FRAC_BITS;
    localparam int SUM_W     = 31 + K_W;

    typedef enum logic [4:0] {
        S_IDLE, S_WR_MEAN, S_WR_SIG, S_SIG_SQ, S_SIG_DIV0, S_DIV,
        S_LOG_NORM, S_LOG_SQ, S_LOG_SQR, S_LN_MUL, S_LN_RES,
        S_FT_RD, S_FT_D, S_FT_M2, S_FT_ACC,
        S_LSE_Z, S_EXP_U, S_EXP_U2, S_EXP_M, S_EXP_MR, S_EXP_ADD
    } state_t;

    state_t                  state_reg;
    logic [1:0]              op_reg;
    logic signed [15:0]      val_reg;
    logic                    last_reg;
    logic [2:0]              mix_reg;
    logic [5:0]              dims_reg;
    logic [3:0]              mixes_reg;
    logic                    flag_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [K_W-1:0]          k_reg;
    logic signed [31:0]      acc_reg [MAX_MIXTURES];
    logic signed [31:0]      lw_reg  [MAX_MIXTURES];
    logic [63:0]             mul_p_reg;
    logic [LOG_W-1:0]        lx_reg;
    logic [5:0]              le_reg;
    logic [31:0]             lm_reg;
    logic [15:0]             lfrac_reg;
    logic [3:0]              lstep_reg;
    logic [4:0]              loff_reg;
    logic [31:0]             rem_reg;
    logic [31:0]             sq_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]    dcnt_reg;
    logic [31:0]             wr_inv_reg;
    logic signed [31:0]      wr_ln_reg;
    logic signed [31:0]      mx_reg;
    logic [15:0]             ufrac_reg;
    logic [4:0]              n_reg;
    logic [3:0]              ei_reg;
    logic [30:0]             r_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    done_reg;
    result_t                 result_reg;

    logic signed [15:0]      mean_mem [DEPTH];
    logic [31:0]             inv_mem  [DEPTH];
    logic signed [31:0]      lnn_mem  [DEPTH];
    logic signed [15:0]      mean_rd_reg;
    logic [31:0]             inv_rd_reg;
    logic signed [31:0]      lnn_rd_reg;

    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [K_W-1:0]          nm;
    logic                    k_last;
    logic [KI_W-1:0]         k_idx;
    logic signed [16:0]      d_diff;
    logic [16:0]             d_abs;
    logic [63:0]             dist_full;
    logic [30:0]             dist_sat;
    logic signed [35:0]      acc_sum;
    logic signed [35:0]      z_sum;
    logic signed [31:0]      z_new;
    logic signed [23:0]      l2;
    logic [23:0]             ln_mag;
    logic [31:0]             ln_r;
    logic signed [31:0]      ln_val;
    logic [33:0]             u_full;
    logic [30:0]             r_prod;
    logic [31:0]             sq_t;
    logic [31:0]             rem_sh;
    logic [63:0]             quo64;
    logic                    exp_bit;
    logic [29:0]             tab_val;
    logic                    accept;
    logic                    ld_ok;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;
    assign accept    = start && !busy;
    assign ld_ok     = (int'(item.mixture_index) < MAX_MIXTURES)
                    && (int'(item.dim_index) < MAX_DIMS);

    always_comb
    begin
        if (mixes_reg == 4'd0) begin
            nm = K_W'(1);
        end
        else if (int'(mixes_reg) > MAX_MIXTURES) begin
            nm = K_W'(MAX_MIXTURES);
        end
        else begin
            nm = K_W'(mixes_reg);
        end
    end

    assign k_last    = ((k_reg + K_W'(1)) == nm);
    assign k_idx     = k_reg[KI_W-1:0];
    assign d_diff    = 17'(val_reg) - 17'(mean_rd_reg);
    assign d_abs     = d_diff[16] ? 17'(-d_diff) : 17'(d_diff);
    assign dist_full = mul_p_reg >> DIST_SH;
    assign dist_sat  = (dist_full > 64'(I32_MAX)) ? 31'h7FFF_FFFF : dist_full[30:0];
    assign acc_sum   = 36'(acc_reg[k_idx]) + 36'(lnn_rd_reg) - $signed({5'b0, dist_sat});
    assign z_sum     = 36'(lw_reg[k_idx]) + 36'(acc_reg[k_idx]);
    assign z_new     = sat32(z_sum);
    assign l2        = $signed({2'b0, le_reg, lfrac_reg}) - $signed({3'b0, loff_reg, 16'b0});
    assign ln_mag    = l2[23] ? 24'(-l2) : 24'(l2);
    assign ln_r      = 32'((mul_p_reg + 64'h8000_0000) >> 32);
    assign ln_val    = l2[23] ? -$signed(ln_r) : $signed(ln_r);
    assign u_full    = 34'((mul_p_reg + 64'h2000_0000) >> 30);
    assign r_prod    = 31'((mul_p_reg + 64'h2000_0000) >> 30);
    assign sq_t      = mul_p_reg[61:30];
    assign rem_sh    = {rem_reg[30:0], (dcnt_reg == DIV_CNT_W'(DIV_W - 1))};
    assign quo64     = 64'(quo_reg);
    assign exp_bit   = ufrac_reg[4'd15 - ei_reg];
    assign tab_val   = POW2_FRAC_TAB[int'(ei_reg)*30 +: 30];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SIG_SQ:
            begin
                mul_a = {16'b0, val_reg};
                mul_b = {16'b0, val_reg};
            end
            S_LOG_SQ:
            begin
                mul_a = lm_reg;
                mul_b = lm_reg;
            end
            S_LN_MUL:
            begin
                mul_a = {8'b0, ln_mag};
                mul_b = LN2_Q32;
            end
            S_FT_D:
            begin
                mul_a = {15'b0, d_abs};
                mul_b = {15'b0, d_abs};
            end
            S_FT_M2:
            begin
                mul_a = mul_p_reg[31:0];
                mul_b = inv_rd_reg[31] ? 32'd0 : inv_rd_reg;
            end
            S_EXP_U:
            begin
                mul_a = mx_reg - acc_reg[k_idx];
                mul_b = LOG2E_Q30;
            end
            S_EXP_M:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = exp_bit ? {2'b0, tab_val} : Q30_ONE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR_MEAN) begin
            mean_mem[addr_reg] <= val_reg;
        end
        if (state_reg == S_WR_SIG) begin
            inv_mem[addr_reg] <= wr_inv_reg;
            lnn_mem[addr_reg] <= wr_ln_reg;
        end
        mean_rd_reg <= mean_mem[addr_reg];
        inv_rd_reg  <= inv_mem[addr_reg];
        lnn_rd_reg  <= lnn_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_WEIGHT;
            val_reg    <= '0;
            last_reg   <= 1'b0;
            mix_reg    <= '0;
            dims_reg   <= 6'd32;
            mixes_reg  <= 4'd8;
            flag_reg   <= 1'b0;
            addr_reg   <= '0;
            k_reg      <= '0;
            for (int i = 0; i < MAX_MIXTURES; i++) begin
                acc_reg[i] <= '0;
                lw_reg[i]  <= '0;
            end
            lx_reg     <= '0;
            le_reg     <= '0;
            lm_reg     <= '0;
            lfrac_reg  <= '0;
            lstep_reg  <= '0;
            loff_reg   <= '0;
            rem_reg    <= '0;
            sq_reg     <= '0;
            quo_reg    <= '0;
            dcnt_reg   <= '0;
            wr_inv_reg <= '0;
            wr_ln_reg  <= '0;
            mx_reg     <= I32_MIN;
            ufrac_reg  <= '0;
            n_reg      <= '0;
            ei_reg     <= '0;
            r_reg      <= '0;
            sum_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else begin
            done_reg <= (state_reg == S_LN_RES) && (op_reg == OP_FEATURE);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DIMS:  dims_reg  <= cfg_data[5:0];
                    CFG_MIXES: mixes_reg <= cfg_data[3:0];
                    default:   ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept) begin
                        op_reg   <= item.opcode;
                        val_reg  <= item.value;
                        last_reg <= item.frame_last;
                        mix_reg  <= item.mixture_index;
                        addr_reg <= (item.opcode == OP_FEATURE)
                                    ? ADDR_W'(item.dim_index)
                                    : ADDR_W'(int'(item.mixture_index) * MAX_DIMS
                                              + int'(item.dim_index));
                        case (item.opcode)
                            OP_WEIGHT:
                            begin
                                if (int'(item.mixture_index) < MAX_MIXTURES) begin
                                    if (item.value <= 16'sd0) begin
                                        lw_reg[KI_W'(item.mixture_index)] <= I32_MIN;
                                    end
                                    else begin
                                        lx_reg    <= LOG_W'(item.value);
                                        le_reg    <= 6'(LOG_W - 1);
                                        lfrac_reg <= '0;
                                        lstep_reg <= 4'd15;
                                        loff_reg  <= 5'(WEIGHT_FRAC);
                                        state_reg <= S_LOG_NORM;
                                    end
                                end
                            end
                            OP_MEAN:
                            begin
                                if (ld_ok) begin
                                    state_reg <= S_WR_MEAN;
                                end
                            end
                            OP_SIGMA:
                            begin
                                if (ld_ok) begin
                                    if (item.value <= 16'sd0) begin
                                        flag_reg   <= 1'b1;
                                        wr_inv_reg <= '0;
                                        wr_ln_reg  <= '0;
                                        state_reg  <= S_WR_SIG;
                                    end
                                    else begin
                                        state_reg <= S_SIG_SQ;
                                    end
                                end
                            end
                            default:
                            begin
                                k_reg    <= '0;
                                if (({1'b0, item.dim_index} < dims_reg)
                                    && (int'(item.dim_index) < MAX_DIMS)) begin
                                    state_reg <= S_FT_RD;
                                end
                                else if (item.frame_last) begin
                                    mx_reg    <= I32_MIN;
                                    state_reg <= S_LSE_Z;
                                end
                            end
                        endcase
                    end
                end
                S_WR_MEAN:
                begin
                    state_reg <= S_IDLE;
                end
                S_WR_SIG:
                begin
                    state_reg <= S_IDLE;
                end
                S_SIG_SQ:
                begin
                    state_reg <= S_SIG_DIV0;
                end
                S_SIG_DIV0:
                begin
                    sq_reg    <= mul_p_reg[31:0];
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dcnt_reg  <= DIV_CNT_W'(DIV_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= sq_reg) begin
                        rem_reg <= rem_sh - sq_reg;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end
                    else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                    if (dcnt_reg == '0) begin
                        lx_reg    <= LOG_W'(val_reg);
                        le_reg    <= 6'(LOG_W - 1);
                        lfrac_reg <= '0;
                        lstep_reg <= 4'd15;
                        loff_reg  <= 5'(VALUE_FRAC_BITS);
                        state_reg <= S_LOG_NORM;
                    end
                    else begin
                        dcnt_reg <= dcnt_reg - DIV_CNT_W'(1);
                    end
                end
                S_LOG_NORM:
                begin
                    if (lx_reg[LOG_W-1]) begin
                        lm_reg    <= {1'b0, lx_reg[LOG_W-1 -: 31]};
                        state_reg <= S_LOG_SQ;
                    end
                    else begin
                        lx_reg <= lx_reg << 1;
                        le_reg <= le_reg - 6'd1;
                    end
                end
                S_LOG_SQ:
                begin
                    state_reg <= S_LOG_SQR;
                end
                S_LOG_SQR:
                begin
                    if (sq_t[31]) begin
                        lm_reg               <= sq_t >> 1;
                        lfrac_reg[lstep_reg] <= 1'b1;
                    end
                    else begin
                        lm_reg <= sq_t;
                    end
                    if (lstep_reg == 4'd0) begin
                        state_reg <= S_LN_MUL;
                    end
                    else begin
                        lstep_reg <= lstep_reg - 4'd1;
                        state_reg <= S_LOG_SQ;
                    end
                end
                S_LN_MUL:
                begin
                    state_reg <= S_LN_RES;
                end
                S_LN_RES:
                begin
                    case (op_reg)
                        OP_WEIGHT:
                        begin
                            lw_reg[KI_W'(mix_reg)] <= ln_val;
                            state_reg              <= S_IDLE;
                        end
                        OP_SIGMA:
                        begin
                            wr_inv_reg <= (quo64 > 64'(I32_MAX)) ? I32_MAX
                                                                 : {1'b0, quo64[30:0]};
                            wr_ln_reg  <= sat32(-LN_SQRT_TWO_PI_Q16 - 36'(ln_val));
                            state_reg  <= S_WR_SIG;
                        end
                        default:
                        begin
                            result_reg.log_likelihood <= sat32(36'(mx_reg) + 36'(ln_val));
                            result_reg.status         <= flag_reg;
                            for (int i = 0; i < MAX_MIXTURES; i++) begin
                                acc_reg[i] <= '0;
                            end
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_FT_RD:
                begin
                    state_reg <= S_FT_D;
                end
                S_FT_D:
                begin
                    state_reg <= S_FT_M2;
                end
                S_FT_M2:
                begin
                    state_reg <= S_FT_ACC;
                end
                S_FT_ACC:
                begin
                    acc_reg[k_idx] <= sat32(acc_sum);
                    addr_reg       <= addr_reg + ADDR_W'(MAX_DIMS);
                    if (!k_last) begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_FT_RD;
                    end
                    else if (last_reg) begin
                        k_reg     <= '0;
                        mx_reg    <= I32_MIN;
                        state_reg <= S_LSE_Z;
                    end
                    else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_LSE_Z:
                begin
                    acc_reg[k_idx] <= z_new;
                    if (z_new > mx_reg) begin
                        mx_reg <= z_new;
                    end
                    if (k_last) begin
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_EXP_U;
                    end
                    else begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                S_EXP_U:
                begin
                    state_reg <= S_EXP_U2;
                end
                S_EXP_U2:
                begin
                    ei_reg    <= '0;
                    ufrac_reg <= u_full[15:0];
                    if (u_full[33:16] > 18'd30) begin
                        r_reg     <= '0;
                        n_reg     <= '0;
                        state_reg <= S_EXP_ADD;
                    end
                    else begin
                        r_reg     <= Q30_ONE[30:0];
                        n_reg     <= u_full[20:16];
                        state_reg <= S_EXP_M;
                    end
                end
                S_EXP_M:
                begin
                    state_reg <= S_EXP_MR;
                end
                S_EXP_MR:
                begin
                    r_reg <= r_prod;
                    if (ei_reg == 4'd15) begin
                        state_reg <= S_EXP_ADD;
                    end
                    else begin
                        ei_reg    <= ei_reg + 4'd1;
                        state_reg <= S_EXP_M;
                    end
                end
                S_EXP_ADD:
                begin
                    sum_reg <= sum_reg + SUM_W'(r_reg >> n_reg);
                    if (k_last) begin
                        lx_reg    <= LOG_W'(sum_reg + SUM_W'(r_reg >> n_reg));
                        le_reg    <= 6'(LOG_W - 1);
                        lfrac_reg <= '0;
                        lstep_reg <= 4'd15;
                        loff_reg  <= 5'(LSE_FRAC);
                        state_reg <= S_LOG_NORM;
                    end
                    else begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_EXP_U;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_load_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.opcode == OP_SIGMA && item.value > 16'sd0
            && int'(item.mixture_index) < MAX_MIXTURES
            && int'(item.dim_index) < MAX_DIMS) |=> busy)
        else $error("sigma load did not start the sequencer");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (sq_reg != 32'd0))
        else $error("divide by zero variance");
`endif

endmodule

// ===== dv/tb_diag_gmm_log_likelihood_unit.sv =====
// Testbench for diag_gmm_log_likelihood_unit: loads a full model, runs directed and random frames.
// Predicts every frame score in fixed point and checks each result word in order.
// Depends on diag_gmm_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_diag_gmm_log_likelihood_unit;
    import diag_gmm_pkg::*;

    localparam int NDIM       = 32;
    localparam int NMIX       = 8;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 600;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    diag_gmm_log_likelihood_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scoring model state
    longint unsigned half_pow_tab [16];
    shortint         mean_mem [NMIX*NDIM];
    int              inv_var_mem [NMIX*NDIM];
    int              norm_mem [NMIX*NDIM];
    int              logw_mem [NMIX];
    int              score_acc [NMIX];
    bit              sigma_fault;
    bit [5:0]        dims_reg;
    bit [3:0]        mixes_reg;

    result_t         score_q [$];
    int              idle_pct;
    int              mismatches;
    int              words_sent;
    int              frames_scored;
    int              reg_writes;
    int              stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log2_fix(input longint unsigned x);
        int              e;
        longint unsigned m;
        longint          res;
        if (x == 0) return 0;
        e = 63;
        while (((x >> e) & 64'd1) == 0) e--;
        m   = (e > 30) ? (x >> (e - 30)) : (x << (30 - e));
        res = longint'(e) <<< 16;
        for (int i = 15; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m   = m >> 1;
                res = res + (64'sd1 <<< i);
            end
        end
        return res;
    endfunction

    function automatic longint ln_from_log2(input longint l2);
        longint unsigned mag;
        longint          r;
        mag = (l2 < 0) ? longint'(-l2) : l2;
        r   = longint'((mag * 64'd2977044472 + (64'd1 << 31)) >> 32);
        return (l2 < 0) ? -r : r;
    endfunction

    function automatic longint unsigned exp_neg(input longint unsigned mag);
        longint unsigned u;
        longint unsigned n;
        longint unsigned r;
        u = (mag * 64'd1549082005 + (64'd1 << 29)) >> 30;
        n = u >> 16;
        r = 64'd1 << 30;
        if (n > 30) return 0;
        for (int i = 0; i < 16; i++)
        begin
            if (((u >> (15 - i)) & 64'd1) != 0)
                r = (r * half_pow_tab[i] + (64'd1 << 29)) >> 30;
        end
        return r >> n;
    endfunction

    task automatic score_word(input item_t w);
        longint          v;
        longint          d;
        longint          z [NMIX];
        longint          top;
        longint unsigned t;
        longint unsigned iv;
        longint unsigned sum;
        int              nm;
        int              a;
        result_t         r;
        v  = longint'($signed(w.value));
        nm = (mixes_reg < 1) ? 1 : ((mixes_reg > NMIX) ? NMIX : mixes_reg);
        a  = w.mixture_index * NDIM + w.dim_index;
        case (w.opcode)
            OP_WEIGHT:
                logw_mem[w.mixture_index] = (v <= 0) ? int'(-64'sd2147483648)
                    : int'(clip32(ln_from_log2(log2_fix(v) - (64'sd14 <<< 16))));
            OP_MEAN:
                mean_mem[a] = shortint'(v);
            OP_SIGMA:
            begin
                if (v <= 0)
                begin
                    sigma_fault    = 1'b1;
                    inv_var_mem[a] = 0;
                    norm_mem[a]    = 0;
                end
                else
                begin
                    t = (64'd1 << 39) / longint'(v * v);
                    inv_var_mem[a] = (t > 64'd2147483647) ? 32'h7FFF_FFFF : int'(t);
                    norm_mem[a] = int'(clip32(-64'sd60224
                        - ln_from_log2(log2_fix(v) - (64'sd12 <<< 16))));
                end
            end
            default:
            begin
                if (w.dim_index < dims_reg)
                begin
                    for (int k = 0; k < nm; k++)
                    begin
                        a  = k * NDIM + w.dim_index;
                        d  = v - longint'(mean_mem[a]);
                        iv = (inv_var_mem[a] < 0) ? 0 : longint'(inv_var_mem[a]);
                        t  = (longint'(d * d) * iv) >> 24;
                        if (t > 64'd2147483647) t = 64'd2147483647;
                        score_acc[k] = int'(clip32(longint'(score_acc[k])
                            + longint'(norm_mem[a]) - longint'(t)));
                    end
                end
                if (w.frame_last)
                begin
                    top = -64'sd2147483648;
                    sum = 0;
                    for (int k = 0; k < nm; k++)
                    begin
                        z[k] = clip32(longint'(logw_mem[k]) + longint'(score_acc[k]));
                        if (z[k] > top) top = z[k];
                    end
                    for (int k = 0; k < nm; k++) sum += exp_neg(top - z[k]);
                    r.log_likelihood = 32'(clip32(top
                        + ln_from_log2(log2_fix(sum) - (64'sd30 <<< 16))));
                    r.status = sigma_fault;
                    score_q.push_back(r);
                    for (int k = 0; k < NMIX; k++) score_acc[k] = 0;
                end
            end
        endcase
    endtask

    function automatic item_t mk(input logic [1:0] op, input int mix, input int dim,
                                 input int val, input bit last);
        item_t w;
        w.opcode        = op;
        w.mixture_index = mix[2:0];
        w.dim_index     = dim[4:0];
        w.value         = val[15:0];
        w.frame_last    = last;
        return w;
    endfunction

    task automatic send_word(input item_t w);
        int gap;
        item  <= w;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        score_word(w);
        words_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(6, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        start <= 1'b0;
        while (score_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DIMS) dims_reg = data[5:0];
        else if (idx == CFG_MIXES) mixes_reg = data[3:0];
        reg_writes++;
    endtask

    function automatic int rand_sigma();
        return (($urandom_range(3) == 0) ? $urandom_range(32767, 1)
                                          : $urandom_range(16384, 256));
    endfunction

    task automatic send_load();
        case ($urandom_range(2))
            0: send_word(mk(OP_WEIGHT, $urandom_range(7), $urandom_range(31),
                            $urandom_range(32767, 1), 1'($urandom_range(1))));
            1: send_word(mk(OP_MEAN, $urandom_range(7), $urandom_range(31),
                            $urandom, 1'($urandom_range(1))));
            default: send_word(mk(OP_SIGMA, $urandom_range(7), $urandom_range(31),
                                  rand_sigma(), 1'($urandom_range(1))));
        endcase
    endtask

    task automatic test_model_load();
        idle_pct = 0;
        write_reg(CFG_DIMS, 8'd32);
        write_reg(CFG_MIXES, 8'd8);
        for (int k = 0; k < NMIX; k++)
            send_word(mk(OP_WEIGHT, k, 0, $urandom_range(32767, 1), 1'b0));
        for (int k = 0; k < NMIX; k++)
        begin
            for (int j = 0; j < NDIM; j++)
            begin
                send_word(mk(OP_MEAN, k, j, $urandom_range(8192) - 4096, 1'b0));
                send_word(mk(OP_SIGMA, k, j, rand_sigma(), 1'b0));
            end
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        send_word(mk(OP_FEATURE, 0, 0, 32767, 1'b0));
        send_word(mk(OP_FEATURE, 7, 31, -32768, 1'b1));
        send_word(mk(OP_MEAN, 7, 31, -32768, 1'b1));
        send_word(mk(OP_WEIGHT, 0, 31, 32767, 1'b0));
        send_word(mk(OP_WEIGHT, 1, 0, 1, 1'b1));
        send_word(mk(OP_SIGMA, 3, 5, 1, 1'b0));
        send_word(mk(OP_SIGMA, 4, 5, 32767, 1'b0));
        send_word(mk(OP_FEATURE, 0, 5, 12345, 1'b1));
        write_reg(CFG_DIMS, 8'd4);
        send_word(mk(OP_FEATURE, 2, 3, -700, 1'b0));
        send_word(mk(OP_FEATURE, 0, 31, 999, 1'b1));
        write_reg(2'd2, 8'hFF);
        write_reg(2'd3, 8'h5A);
        write_reg(CFG_MIXES, 8'd1);
        send_word(mk(OP_WEIGHT, 0, 0, 0, 1'b0));
        send_word(mk(OP_FEATURE, 0, 1, 100, 1'b1));
        send_word(mk(OP_WEIGHT, 0, 0, -32768, 1'b0));
        send_word(mk(OP_FEATURE, 0, 2, -100, 1'b1));
        send_word(mk(OP_WEIGHT, 0, 0, 16384, 1'b0));
        write_reg(CFG_MIXES, 8'd8);
        send_word(mk(OP_SIGMA, 2, 2, 0, 1'b0));
        send_word(mk(OP_FEATURE, 0, 2, 50, 1'b1));
        send_word(mk(OP_SIGMA, 5, 1, -32768, 1'b0));
        send_word(mk(OP_FEATURE, 0, 1, 0, 1'b1));
        send_word(mk(OP_SIGMA, 2, 2, 4096, 1'b0));
        send_word(mk(OP_SIGMA, 5, 1, 2048, 1'b0));
    endtask

    task automatic run_frame();
        int span;
        int n;
        span = (dims_reg == 0) ? 1 : ((dims_reg > NDIM) ? NDIM : dims_reg);
        n    = $urandom_range(span, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0) send_load();
            if ($urandom_range(9) == 0)
                send_word(mk(OP_FEATURE, $urandom_range(7), $urandom_range(31),
                             $urandom, i == n - 1));
            else
                send_word(mk(OP_FEATURE, $urandom_range(7), (i * span) / n,
                             $urandom_range(12000) - 6000, i == n - 1));
        end
    endtask

    task automatic test_random();
        int dims_tab [8] = '{32, 1, 32, 5, 0, 63, 17, 32};
        int mix_tab  [8] = '{8, 1, 8, 3, 0, 15, 6, 8};
        int idle_tab [8] = '{0, 66, 66, 11, 0, 11, 66, 0};
        int first;
        for (int p = 0; p < 8; p++)
        begin
            write_reg(CFG_DIMS, 8'(dims_tab[p]));
            write_reg(CFG_MIXES, 8'(mix_tab[p]));
            idle_pct = idle_tab[p];
            first    = words_sent;
            while (words_sent - first < 90) run_frame();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (score_q.size() == 0)
            begin
                $display("%0t: unexpected result ll=%0d status=%0d", $time,
                         result.log_likelihood, result.status);
                mismatches++;
            end
            else
            begin
                if (result.log_likelihood !== score_q[0].log_likelihood)
                begin
                    $display("%0t: log_likelihood expected %0d actual %0d", $time,
                             score_q[0].log_likelihood, result.log_likelihood);
                    mismatches++;
                end
                if (result.status !== score_q[0].status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             score_q[0].status, result.status);
                    mismatches++;
                end
                void'(score_q.pop_front());
                frames_scored++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        mismatches    = 0;
        words_sent    = 0;
        frames_scored = 0;
        reg_writes    = 0;
        stall_cycles  = 0;
        idle_pct      = 0;
        dims_reg      = 6'd32;
        mixes_reg     = 4'd8;
        sigma_fault   = 1'b0;
        for (int k = 0; k < NMIX; k++) score_acc[k] = 0;
        half_pow_tab[0] = int_root(64'd1 << 59);
        for (int i = 1; i < 16; i++) half_pow_tab[i] = int_root(half_pow_tab[i-1] << 30);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_model_load();
        test_directed();
        test_random();

        start <= 1'b0;
        while (score_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d words, scored %0d frames, %0d register writes", words_sent,
                 frames_scored, reg_writes);
        $display("Covered model loads, sigma faults, range edges and idle mixes");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/diag_gmm_pkg.sv
rtl/diag_gmm_log_likelihood_unit.sv
dv/tb_diag_gmm_log_likelihood_unit.sv
